FILE: rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkv_ctrl, lkv_datapath and lru_key_value_cache; no dependencies.
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int DATA_W  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic lookup;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic rsp_stall;
   } status_type;

endpackage

FILE: rtl/lkv_ctrl.sv
// Sequencer for the LRU key-value cache: capture, lookup, update.
// Depends on lkv_pkg; drives the command struct into lkv_datapath.
module lkv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  lkv_pkg::status_type status,
   output lkv_pkg::cmd_type    cmd
);
   import lkv_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready  = 1'b1;
            req_tready = !csr_valid;
            cmd.clear  = csr_valid;
            if (req_tvalid && !csr_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!status.rsp_stall) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/lkv_datapath.sv
// Entry store, parallel key compare, recency ranks and result register.
// Depends on lkv_pkg; sequenced by lkv_ctrl through cmd_type.
module lkv_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  lkv_pkg::cmd_type             cmd,
   input  logic [2*lkv_pkg::DATA_W-1:0] req_tdata,
   input  logic                         req_tuser,
   input  logic [lkv_pkg::CAP_W-1:0]    csr_wdata,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [lkv_pkg::DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                   rsp_tuser,
   output lkv_pkg::status_type          status
);
   import lkv_pkg::*;

   logic [CAP_W-1:0]  cap_ff;
   op_type            op_ff;
   logic [DATA_W-1:0] key_ff, val_ff;

   logic [DATA_W-1:0] entry_key_ff   [ENTRIES];
   logic [DATA_W-1:0] entry_value_ff [ENTRIES];
   logic [IDX_W-1:0]  rank_ff        [ENTRIES];
   logic [IDX_W-1:0]  rank_in        [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic               hit_ff;
   logic [ENTRIES-1:0] match_ff, victim_ff;
   logic [IDX_W-1:0]   found_rank_ff;
   logic [DATA_W-1:0]  rdval_ff;
   logic               full_ff;

   logic               rsp_valid_ff, rsp_hit_ff, rsp_evict_ff;
   logic [DATA_W-1:0]  rsp_value_ff;

   logic [ENTRIES-1:0] eq, match_first, vic_raw, vic_first;
   logic [IDX_W-1:0]   found_rank, last_rank;
   logic [DATA_W-1:0]  rdval;
   logic [CMP_W-1:0]   cap_ext, eff_cap;

   logic [ENTRIES-1:0] wr_key, wr_val, keep, free_oh;
   logic               evict, put_hit, put_new;

   // lookup
   always_comb begin
      eq         = '0;
      vic_raw    = '0;
      found_rank = '0;
      rdval      = '0;
      last_rank  = IDX_W'(count_ff - CNT_W'(1));
      for (int i = 0; i < ENTRIES; i++) begin
         eq[i]      = valid_ff[i] && (entry_key_ff[i] == key_ff);
         vic_raw[i] = valid_ff[i] && (rank_ff[i] == last_rank);
      end
      match_first = eq & (~eq + ENTRIES'(1));
      vic_first   = vic_raw & (~vic_raw + ENTRIES'(1));
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_first[i]) begin
            found_rank = found_rank | rank_ff[i];
            rdval      = rdval | entry_value_ff[i];
         end
      end
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   // update
   always_comb begin
      put_hit  = (op_ff == OP_PUT) && hit_ff;
      put_new  = (op_ff == OP_PUT) && !hit_ff;
      evict    = put_new && full_ff;
      keep     = valid_ff & ~(evict ? victim_ff : '0);
      free_oh  = ~keep & (keep + ENTRIES'(1));
      valid_in = valid_ff;
      count_in = count_ff;
      wr_key   = '0;
      wr_val   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (hit_ff) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (match_ff[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && rank_ff[i] < found_rank_ff) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
         if (put_hit) begin
            wr_val = match_ff;
         end
      end else if (put_new) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (keep[i]) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end else begin
               rank_in[i] = '0;
            end
         end
         valid_in = keep | free_oh;
         wr_key   = free_oh;
         wr_val   = free_oh;
         if (!evict && (free_oh != '0)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.clear) begin
         cap_ff   <= csr_wdata;
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (wr_key[i]) begin
               entry_key_ff[i] <= key_ff;
            end
            if (wr_val[i]) begin
               entry_value_ff[i] <= val_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= op_type'(req_tuser);
         key_ff <= req_tdata[DATA_W-1:0];
         val_ff <= req_tdata[2*DATA_W-1:DATA_W];
      end
      if (cmd.lookup) begin
         hit_ff        <= (eq != '0);
         match_ff      <= match_first;
         victim_ff     <= vic_first;
         found_rank_ff <= found_rank;
         rdval_ff      <= rdval;
         full_ff       <= (CMP_W'(count_ff) >= eff_cap);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit_ff   <= hit_ff;
         rsp_evict_ff <= evict;
         if (op_ff == OP_PUT) begin
            rsp_value_ff <= '0;
         end else if (hit_ff) begin
            rsp_value_ff <= rdval_ff;
         end else begin
            rsp_value_ff <= '1;
         end
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_value_ff;
   assign rsp_tuser        = {rsp_evict_ff, rsp_hit_ff};
   assign status.rsp_stall = rsp_valid_ff && !rsp_tready;

endmodule

FILE: rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: sequencer plus datapath.
// Depends on lkv_pkg, lkv_ctrl and lkv_datapath.
//
// Fully associative store of 16 key/value pairs with least-recently-used
// replacement. Each request beat is a get or a put; each yields exactly one
// response beat. A request steps through capture, parallel key compare and
// rank lookup, then store update and result load, in the three-state
// sequencer; the update waits while the response stays stalled. A new
// request is taken while the previous response still waits in the output
// register. A write on the csr channel sets the capacity and clears the
// store; capacity 0 acts as 1 and values above 16 act as 16.
module lru_key_value_cache (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [2*lkv_pkg::DATA_W-1:0]  req_tdata,  // lookup_key, store_value
   input  logic                          req_tuser,  // operation
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lkv_pkg::DATA_W-1:0]    rsp_tdata,  // read_value
   output logic [1:0]                    rsp_tuser,  // hit, evicted
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0]     csr_wdata   // capacity
);
   import lkv_pkg::*;

   cmd_type    cmd;
   status_type status;

   lkv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .status     (status),
      .cmd        (cmd)
   );

   lkv_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .status     (status)
   );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for lru_key_value_cache: directed and random get/put beats,
// capacity writes between phases, with a scoreboard fed by a behavioral LRU model.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lkv_pkg::*;

   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
   } cache_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [2*DATA_W-1:0] req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DATA_W-1:0]   rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_wdata = '0;

   // cache model state
   logic [DATA_W-1:0]   model_key [ENTRIES];
   logic [DATA_W-1:0]   model_value [ENTRIES];
   bit                  model_valid [ENTRIES];
   int                  model_rank [ENTRIES];
   logic [CAP_W-1:0]    model_capacity;

   cache_result_type    pending_results[$];
   int                  error_count = 0;
   int                  idle_cycles = 0;
   bit                  req_idle_on = 1'b1;
   bit                  rsp_idle_on = 1'b1;
   int                  rsp_hold_req = 0;
   int                  rsp_hold_left = 0;
   int                  rsp_stall_left = 0;

   lru_key_value_cache i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void clear_model();
      for (int i = 0; i < ENTRIES; i++) begin
         model_key[i]   = '0;
         model_value[i] = '0;
         model_valid[i] = 1'b0;
         model_rank[i]  = 0;
      end
   endfunction

   function automatic int effective_capacity(input logic [CAP_W-1:0] cap);
      int c;
      c = int'(cap);
      if (c < 1) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
   endfunction

   function automatic void promote_entry(input int slot);
      int r;
      r = model_rank[slot];
      for (int i = 0; i < ENTRIES; i++)
         if (model_valid[i] && model_rank[i] < r) model_rank[i]++;
      model_rank[slot] = 0;
   endfunction

   task automatic predict_access(input op_type op, input logic [DATA_W-1:0] key,
                                 input logic [DATA_W-1:0] value,
                                 output cache_result_type res);
      int found;
      int count;
      int victim;
      int slot;
      found  = -1;
      count  = 0;
      victim = -1;
      slot   = -1;
      res    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (model_valid[i]) begin
            count++;
            if (found < 0 && model_key[i] == key) found = i;
         end
      end
      if (op == OP_GET) begin
         if (found >= 0) begin
            res.hit        = 1'b1;
            res.read_value = model_value[found];
            promote_entry(found);
         end else begin
            res.read_value = '1;
         end
      end else if (found >= 0) begin
         res.hit            = 1'b1;
         model_value[found] = value;
         promote_entry(found);
      end else begin
         if (count >= effective_capacity(model_capacity)) begin
            for (int i = 0; i < ENTRIES; i++)
               if (model_valid[i] && (victim < 0 || model_rank[i] > model_rank[victim]))
                  victim = i;
            if (victim >= 0) begin
               model_valid[victim] = 1'b0;
               model_rank[victim]  = 0;
               res.evicted         = 1'b1;
            end
         end
         for (int i = 0; i < ENTRIES; i++)
            if (model_valid[i]) model_rank[i]++;
         for (int i = 0; i < ENTRIES; i++)
            if (!model_valid[i] && slot < 0) slot = i;
         if (slot >= 0) begin
            model_valid[slot] = 1'b1;
            model_key[slot]   = key;
            model_value[slot] = value;
            model_rank[slot]  = 0;
         end
      end
   endtask

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_request(input op_type op, input logic [DATA_W-1:0] key,
                               input logic [DATA_W-1:0] value);
      cache_result_type res;
      int               gap;
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, key};
      do @(posedge clock); while (!req_tready);
      predict_access(op, key, value, res);
      pending_results.push_back(res);
      @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (5) @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      do @(posedge clock); while (!csr_ready);
      model_capacity = cap;
      clear_model();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_and_extremes();
      send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
      send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_GET, 32'h8000_0000, 32'h0);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h0000_0000, 32'h0);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_PUT, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
   endtask

   task automatic test_capacity_limits();
      write_capacity(5'd0);
      send_request(OP_PUT, 32'h0000_0001, 32'h1111_1111);
      send_request(OP_PUT, 32'h0000_0002, 32'h2222_2222);
      send_request(OP_GET, 32'h0000_0001, 32'h0);
      send_request(OP_GET, 32'h0000_0002, 32'h0);
      write_capacity(5'd0);
      send_request(OP_GET, 32'h0000_0002, 32'h0);
      write_capacity(5'd31);
      write_capacity(5'd17);
   endtask

   task automatic test_recency_order();
      write_capacity(5'd2);
      send_request(OP_PUT, 32'hA000_0000, 32'h0000_000A);
      send_request(OP_PUT, 32'hB000_0000, 32'h0000_000B);
      send_request(OP_GET, 32'hA000_0000, 32'h0);
      send_request(OP_PUT, 32'hC000_0000, 32'h0000_000C);
      send_request(OP_GET, 32'hB000_0000, 32'h0);
      send_request(OP_GET, 32'hA000_0000, 32'h0);
   endtask

   task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int count);
      logic [DATA_W-1:0] key_pool[$];
      logic [DATA_W-1:0] key;
      op_type            op;
      int                pool_size;
      write_capacity(cap);
      pool_size = effective_capacity(cap) + $urandom_range(1, 4);
      repeat (pool_size) key_pool.push_back($urandom);
      repeat (count) begin
         op  = op_type'($urandom_range(0, 1));
         key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_size - 1)]
                                            : $urandom;
         send_request(op, key, $urandom);
      end
   endtask

   task automatic test_random_mix();
      logic [CAP_W-1:0] caps [10];
      caps = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd5, 5'd8, 5'd15, 5'd31, 5'd17, 5'd3};
      foreach (caps[i]) run_random_phase(caps[i], 100);
      repeat (2) run_random_phase(CAP_W'($urandom_range(0, 31)), 50);
   endtask

   // hold starts only once the store is cleared, so requests keep coming during it
   task automatic test_back_pressure();
      req_idle_on  = 1'b0;
      write_capacity(5'd16);
      rsp_hold_req = 300;
      repeat (40) begin
         send_request(op_type'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom);
      end
      req_idle_on  = 1'b1;
   endtask

   task automatic test_full_rate();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random_phase(CAP_W'($urandom_range(1, 16)), 150);
   endtask

   // receiver: random stall bursts plus an optional long hold
   always @(negedge clock) begin
      if (rsp_hold_req != 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req  = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall_left = $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response scoreboard
   always @(posedge clock) begin
      cache_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response beat: read_value %h hit %b evicted %b",
                   rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_tuser[0] !== exp_res.hit) begin
               $error("hit: expected %b, actual %b", exp_res.hit, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tdata !== exp_res.read_value) begin
               $error("read_value: expected %h, actual %h", exp_res.read_value, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[1] !== exp_res.evicted) begin
               $error("evicted: expected %b, actual %b", exp_res.evicted, rsp_tuser[1]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      model_capacity = CAP_RESET;
      clear_model();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_and_extremes();
      test_capacity_limits();
      test_recency_order();
      test_random_mix();
      test_back_pressure();
      test_full_rate();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      error_count += pending_results.size();
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
